FILE: hw/rtl/source_text_comment_strip_and_spacing_unit_defines.svh
// Shared assertion macros
`ifndef SOURCE_TEXT_COMMENT_STRIP_AND_SPACING_UNIT_DEFINES_SVH
`define SOURCE_TEXT_COMMENT_STRIP_AND_SPACING_UNIT_DEFINES_SVH

// check a condition on every clock outside reset
`define STCSS_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// check that a condition implies another in the next cycle
`define STCSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/stcss_pkg.sv
package stcss_pkg;

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_VT    = 8'h0B;

  localparam int unsigned MAX_OUT = 4;
  localparam int unsigned CNT_W   = $clog2(MAX_OUT + 1);
  localparam int unsigned IDX_W   = $clog2(MAX_OUT);

  typedef struct packed {
    logic [MAX_OUT-1:0][7:0] chars;
    logic [CNT_W-1:0]        cnt;
  } load_t;

  typedef struct packed {
    logic emit;
    logic lws;
    logic ls;
  } sp_t;

  function automatic logic is_ws(input logic [7:0] c);
    return c == CH_SPACE || c == CH_NL || c == CH_CR || c == CH_TAB ||
           c == CH_FF || c == CH_VT;
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return c == CH_STAR || c == CH_PLUS || c == CH_SLASH || c == CH_MINUS;
  endfunction

  // collapse spaces, then drop leading whitespace
  function automatic sp_t sp_step(input logic [7:0] c, input logic lws, input logic ls);
    sp_t r;
    r.emit = 1'b0;
    r.lws  = lws;
    r.ls   = ls;
    if (!(c == CH_SPACE && lws)) begin
      r.lws = (c == CH_SPACE);
      if (ls || !is_ws(c)) begin
        r.ls   = 1'b1;
        r.emit = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/source_text_comment_strip_and_spacing_unit.sv
// Latency: results of an accepted word appear on out_* the next cycle.
// Throughput: one input word per cycle when out_tready is high and each word yields at most one
// output word; more outputs hold the input until the last is taken (operators up to 3, max 4).
// The buffer sends one word per cycle while out_tready is high and reloads as its last is taken.
// Reset: synchronous, active low; clears comment, lookahead and line state and empties the buffer.
module source_text_comment_strip_and_spacing_unit
  import stcss_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] ch
  input  logic       in_tlast,   // end_of_line
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_ch
  output logic       out_tlast   // last
);

  logic  acc;
  logic  can_load;
  load_t load;

  assign in_tready = can_load;
  assign acc       = in_tvalid && can_load;

  stcss_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .ch    (in_tdata),
    .eol   (in_tlast),
    .load  (load)
  );

  stcss_ser u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .load       (load),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: hw/rtl/stcss_core.sv
module stcss_core
  import stcss_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic [7:0] ch,
  input  logic       eol,
  output load_t      load
);

  logic in_comment_r, in_comment_nxt;
  logic pend_r, pend_nxt;
  logic ls_r, ls_nxt;
  logic lws_r, lws_nxt;

  logic [MAX_OUT-1:0]      slot_v;
  logic [MAX_OUT-1:0][7:0] slot_c;

  always_comb begin
    sp_t sp;
    logic lws;
    logic ls;
    sp = '0;
    lws = lws_r;
    ls = ls_r;
    slot_v = '0;
    slot_c = '0;
    in_comment_nxt = in_comment_r;
    pend_nxt = pend_r;
    ls_nxt = ls_r;
    lws_nxt = lws_r;
    priority if (eol) begin
      if (pend_r && !in_comment_r) begin
        sp = sp_step(CH_OPEN, lws, ls);
        slot_v[0] = sp.emit;
        slot_c[0] = CH_OPEN;
        ls = sp.ls;
      end
      slot_v[1] = ls;
      slot_c[1] = CH_NL;
      pend_nxt = 1'b0;
      ls_nxt = 1'b0;
      lws_nxt = 1'b0;
    end else if (in_comment_r) begin
      if (pend_r && ch == CH_CLOSE) begin
        in_comment_nxt = 1'b0;
        pend_nxt = 1'b0;
      end else begin
        pend_nxt = (ch == CH_STAR);
      end
    end else if (pend_r && ch == CH_STAR) begin
      in_comment_nxt = 1'b1;
      pend_nxt = 1'b0;
    end else begin
      if (pend_r) begin
        sp = sp_step(CH_OPEN, lws, ls);
        slot_v[0] = sp.emit;
        slot_c[0] = CH_OPEN;
        lws = sp.lws;
        ls = sp.ls;
      end
      pend_nxt = (ch == CH_OPEN);
      if (ch != CH_OPEN) begin
        if (is_op(ch)) begin
          sp = sp_step(CH_SPACE, lws, ls);
          slot_v[1] = sp.emit;
          slot_c[1] = CH_SPACE;
          lws = sp.lws;
          ls = sp.ls;
          sp = sp_step(ch, lws, ls);
          slot_v[2] = sp.emit;
          slot_c[2] = ch;
          lws = sp.lws;
          ls = sp.ls;
          sp = sp_step(CH_SPACE, lws, ls);
          slot_v[3] = sp.emit;
          slot_c[3] = CH_SPACE;
          lws = sp.lws;
          ls = sp.ls;
        end else begin
          sp = sp_step(ch, lws, ls);
          slot_v[1] = sp.emit;
          slot_c[1] = ch;
          lws = sp.lws;
          ls = sp.ls;
        end
      end
      ls_nxt = ls;
      lws_nxt = lws;
    end
  end

  // pack emitted slots toward index zero
  always_comb begin
    logic [CNT_W-1:0] n;
    n = '0;
    load.chars = '0;
    for (int i = 0; i < MAX_OUT; i++) begin
      if (slot_v[i]) begin
        load.chars[n[IDX_W-1:0]] = slot_c[i];
        n = n + 1'b1;
      end
    end
    load.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_comment_r <= 1'b0;
      pend_r <= 1'b0;
      ls_r <= 1'b0;
      lws_r <= 1'b0;
    end else if (acc) begin
      in_comment_r <= in_comment_nxt;
      pend_r <= pend_nxt;
      ls_r <= ls_nxt;
      lws_r <= lws_nxt;
    end
  end

endmodule

FILE: hw/rtl/stcss_ser.sv
`include "source_text_comment_strip_and_spacing_unit_defines.svh"

module stcss_ser
  import stcss_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  load_t      load,
  output logic       can_load,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tlast
);

  logic [MAX_OUT-1:0][7:0] buf_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [IDX_W-1:0]        idx_r;
  logic                    take;

  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = buf_r[idx_r];
  assign out_tlast  = (cnt_r == CNT_W'(1));
  assign take       = out_tvalid && out_tready;
  assign can_load   = (cnt_r == '0) || (out_tlast && out_tready);

  always_ff @(posedge clk) begin
    if (acc) begin
      buf_r <= load.chars;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else if (acc) begin
      cnt_r <= load.cnt;
      idx_r <= '0;
    end else if (take) begin
      cnt_r <= cnt_r - 1'b1;
      idx_r <= idx_r + 1'b1;
    end
  end

  `STCSS_ASSERT_ALWAYS(a_cnt_range, cnt_r <= CNT_W'(MAX_OUT), "word count out of range")
  `STCSS_ASSERT_ALWAYS(a_idx_fit, ({1'b0, idx_r} + cnt_r) <= (CNT_W + 1)'(MAX_OUT), "index overrun")
  `STCSS_ASSERT_NEXT(a_load_idx, acc, idx_r == '0, "load did not rewind index")
  `STCSS_ASSERT_NEXT(a_drain, take && out_tlast && !acc, cnt_r == '0, "buffer not empty after last word")

endmodule
